@@ hw/rtl/eth_ipv4_tcp_header_parser_macros.svh @@
// Assertion macros for the Ethernet/IPv4/TCP header parser.
// Depends on nothing; included by eth_ipv4_tcp_header_parser, which carries the assertions.
`ifndef ETH_IPV4_TCP_HEADER_PARSER_MACROS_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds in the same cycle as its trigger
`define EITP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define EITP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define EITP_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define EITP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/eitp_pkg.sv @@
// Types and constants for the Ethernet/IPv4/TCP header parser.
// Depends on nothing; imported by eth_ipv4_tcp_header_parser, its result checker and testbench.
package eitp_pkg;

   // Summary status codes
   typedef enum logic [2:0] {
      ST_TCP_OK    = 3'd0,
      ST_NOT_IPV4  = 3'd1,
      ST_NOT_TCP   = 3'd2,
      ST_TRUNCATED = 3'd3,
      ST_MALFORMED = 3'd4
   } status_type;

   // Frame parse phase
   typedef enum logic [1:0] {
      PH_HEAD    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   // Result kinds
   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // Header layout
   localparam logic [15:0] OFF_SRC_MAC    = 16'd6;
   localparam logic [15:0] OFF_ETYPE_HI   = 16'd12;
   localparam logic [15:0] OFF_ETYPE_LO   = 16'd13;
   localparam logic [15:0] OFF_IP_START   = 16'd14;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
   localparam logic [15:0] TCP_OFF_DOFF   = 16'd12;
   localparam logic [7:0]  SHOW_LIMIT_RESET = 8'd10;

   // Input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   // Result item
   typedef struct packed {
      logic        kind;
      status_type  status;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [31:0] dst_ip;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] payload_len;
      logic [7:0]  payload_byte;
      logic        end_res;
   } rsp_type;

endpackage

@@ hw/rtl/eth_ipv4_tcp_header_parser.sv @@
// Ethernet/IPv4/TCP header parser: byte stream in, summary and payload items out.
// Depends on eitp_pkg and eth_ipv4_tcp_header_parser_macros.svh.
//
// An input transfer passes through the input register and then the result register.
// Throughput: one byte per cycle unless stalled; offset compare and capture sit in one stage.
// Reset (synchronous): frame state to header phase at offset zero, show_limit to 10.
`include "eth_ipv4_tcp_header_parser_macros.svh"

module eth_ipv4_tcp_header_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  eitp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output eitp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);
   import eitp_pkg::*;

   // Per-frame capture state
   typedef struct packed {
      phase_type   phase;
      logic [15:0] byte_offset;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [15:0] ether_type;
      logic [3:0]  ip_header_words;
      logic [15:0] ip_total_len;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [3:0]  tcp_header_words;
      logic [7:0]  payload_left;
   } frame_type;

   logic       in_valid_ff;
   req_type    in_ff;
   frame_type  frame_ff, frame_in;
   logic [7:0] show_limit_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       emit_in;
   logic       advance;

   // Result register free or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         show_limit_ff <= SHOW_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         show_limit_ff <= csr_data;
      end
   end

   // Input register: load on transfer, drop once consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   // Frame state register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (in_valid_ff && advance) begin
         frame_ff <= frame_in;
      end
   end

   // Next frame state and result for the held byte
   always_comb begin
      logic [7:0]  b;
      logic [15:0] off;
      logic [15:0] ip_end;
      logic [15:0] ip_rel;
      logic [15:0] tcp_rel;
      logic [15:0] tcp_end_rel;
      logic [6:0]  hdr_bytes;
      logic [15:0] plen;
      logic [7:0]  shown;
      logic        st_valid;
      status_type  st_code;
      logic        end_item;

      b           = in_ff.data_byte;
      off         = frame_ff.byte_offset;
      ip_end      = OFF_IP_START + {10'd0, frame_ff.ip_header_words, 2'b00};
      ip_rel      = off - OFF_IP_START;
      tcp_rel     = off - ip_end;
      tcp_end_rel = {10'd0, frame_ff.tcp_header_words, 2'b00} - 16'd1;
      hdr_bytes   = {1'b0, frame_ff.ip_header_words, 2'b00}
                  + {1'b0, frame_ff.tcp_header_words, 2'b00};
      plen        = '0;
      shown       = '0;
      st_valid    = 1'b0;
      st_code     = ST_TRUNCATED;
      end_item    = 1'b1;
      frame_in    = frame_ff;
      rsp_data_in = '0;
      emit_in     = 1'b0;

      unique case (frame_ff.phase)
         PH_HEAD: begin
            // Capture the field that this offset falls in
            if (off < OFF_SRC_MAC) begin
               frame_in.dst_mac = {frame_ff.dst_mac[39:0], b};
            end else if (off < OFF_ETYPE_HI) begin
               frame_in.src_mac = {frame_ff.src_mac[39:0], b};
            end else if (off == OFF_ETYPE_HI) begin
               frame_in.ether_type = {b, 8'h00};
            end else if (off == OFF_ETYPE_LO) begin
               frame_in.ether_type = {frame_ff.ether_type[15:8], b};
               if (frame_in.ether_type != ETHERTYPE_IPV4) begin
                  st_valid = 1'b1;
                  st_code  = ST_NOT_IPV4;
               end
            end else if (off == OFF_IP_START) begin
               frame_in.ip_header_words = b[3:0];
               if (b[3:0] < MIN_HDR_WORDS) begin
                  st_valid = 1'b1;
                  st_code  = ST_MALFORMED;
               end
            end else if (off < ip_end) begin
               case (ip_rel) inside
                  16'd2, 16'd3: frame_in.ip_total_len = {frame_ff.ip_total_len[7:0], b};
                  16'd9:        frame_in.protocol = b;
                  [16'd12:16'd15]: frame_in.src_ip = {frame_ff.src_ip[23:0], b};
                  [16'd16:16'd19]: frame_in.dst_ip = {frame_ff.dst_ip[23:0], b};
                  default: ;
               endcase
               if (ip_rel == 16'd19 && frame_ff.protocol != PROTO_TCP) begin
                  st_valid = 1'b1;
                  st_code  = ST_NOT_TCP;
               end
            end else begin
               if (tcp_rel < 16'd2) begin
                  frame_in.src_port = {frame_ff.src_port[7:0], b};
               end else if (tcp_rel < 16'd4) begin
                  frame_in.dst_port = {frame_ff.dst_port[7:0], b};
               end else if (tcp_rel == TCP_OFF_DOFF) begin
                  frame_in.tcp_header_words = b[7:4];
                  if (b[7:4] < MIN_HDR_WORDS) begin
                     st_valid = 1'b1;
                     st_code  = ST_MALFORMED;
                  end
               end else if (tcp_rel > TCP_OFF_DOFF && tcp_rel == tcp_end_rel) begin
                  st_valid = 1'b1;
                  st_code  = ST_TCP_OK;
               end
            end

            // Frame ended before the summary was due
            if (!st_valid && in_ff.last) begin
               st_valid = 1'b1;
               st_code  = ST_TRUNCATED;
            end

            // Build the summary and pick the payload count
            if (st_valid) begin
               if (st_code == ST_TCP_OK) begin
                  plen  = (frame_ff.ip_total_len > {9'd0, hdr_bytes})
                        ? frame_ff.ip_total_len - {9'd0, hdr_bytes} : 16'd0;
                  shown = (plen < {8'd0, show_limit_ff}) ? plen[7:0] : show_limit_ff;
                  if (shown != 8'd0 && !in_ff.last) begin
                     end_item              = 1'b0;
                     frame_in.payload_left = shown;
                  end
               end
               emit_in                 = 1'b1;
               rsp_data_in.kind        = KIND_SUMMARY;
               rsp_data_in.status      = st_code;
               rsp_data_in.dst_mac     = frame_in.dst_mac;
               rsp_data_in.src_mac     = frame_in.src_mac;
               rsp_data_in.dst_ip      = frame_in.dst_ip;
               rsp_data_in.src_ip      = frame_in.src_ip;
               rsp_data_in.src_port    = frame_in.src_port;
               rsp_data_in.dst_port    = frame_in.dst_port;
               rsp_data_in.payload_len = plen;
               rsp_data_in.end_res     = end_item;
               frame_in.phase          = end_item ? PH_DONE : PH_PAYLOAD;
            end

            // Advance the offset, saturating
            if (off != 16'hFFFF) begin
               frame_in.byte_offset = off + 16'd1;
            end
         end

         PH_PAYLOAD: begin
            frame_in.payload_left    = frame_ff.payload_left - 8'd1;
            emit_in                  = 1'b1;
            rsp_data_in.kind         = KIND_PAYLOAD;
            rsp_data_in.status       = ST_TCP_OK;
            rsp_data_in.payload_byte = b;
            rsp_data_in.end_res      = (frame_in.payload_left == 8'd0) || in_ff.last;
            if (frame_in.payload_left == 8'd0) begin
               frame_in.phase = PH_DONE;
            end
         end

         default: ;
      endcase

      // Last byte returns the frame state to reset
      if (in_ff.last) begin
         frame_in = '0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff && emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Checks
   `EITP_ASSERT_SAME(a_payload_left_nonzero, clock, reset,
      frame_ff.phase == PH_PAYLOAD, frame_ff.payload_left != 8'd0,
      "payload phase with no bytes left")
   `EITP_ASSERT_NEXT(a_done_is_silent, clock, reset,
      in_valid_ff && advance && frame_ff.phase == PH_DONE, !rsp_valid_ff,
      "result produced after the frame was finished")
   `EITP_ASSERT_NEXT(a_last_clears_frame, clock, reset,
      in_valid_ff && advance && in_ff.last,
      frame_ff.phase == PH_HEAD && frame_ff.byte_offset == 16'd0,
      "frame state not cleared after last byte")

endmodule

@@ test/parser_result_checker.sv @@
// Result checker for the Ethernet/IPv4/TCP header parser: watches all three channels,
// predicts the summary and payload items and compares them. Depends on eitp_pkg.
module parser_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  eitp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  eitp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [7:0]        csr_data,
   output int                mismatches,
   output int                outstanding
);
   import eitp_pkg::*;

   // Own copy of the configuration and of the per-frame capture state
   logic [7:0]  limit;
   logic [15:0] pos;
   logic [47:0] dmac;
   logic [47:0] smac;
   logic [15:0] etype;
   logic [3:0]  ihl;
   logic [15:0] ip_len;
   logic [7:0]  proto;
   logic [31:0] sip;
   logic [31:0] dip;
   logic [15:0] sport;
   logic [15:0] dport;
   logic [3:0]  doff;
   logic [15:0] shown_left;
   phase_type   stage;

   rsp_type parsed_items[$];
   int      error_count = 0;

   // Return every frame register to its idle value
   task automatic clear_frame();
      pos = '0;
      dmac = '0;
      smac = '0;
      etype = '0;
      ihl = '0;
      ip_len = '0;
      proto = '0;
      sip = '0;
      dip = '0;
      sport = '0;
      dport = '0;
      doff = '0;
      shown_left = '0;
      stage = PH_HEAD;
   endtask

   // Advance the parse by one frame byte and queue any item it produces
   task automatic parse_byte(input logic [7:0] b, input logic fin);
      int      st;
      int      ip_end;
      int      r;
      int      plen;
      int      shown;
      logic    done;
      rsp_type item;
      st = -1;
      item = '0;
      if (stage == PH_HEAD) begin
         if (pos < OFF_SRC_MAC) begin
            dmac = {dmac[39:0], b};
         end else if (pos < OFF_ETYPE_HI) begin
            smac = {smac[39:0], b};
         end else if (pos == OFF_ETYPE_HI) begin
            etype = {b, 8'h00};
         end else if (pos == OFF_ETYPE_LO) begin
            etype[7:0] = b;
            if (etype != ETHERTYPE_IPV4) st = ST_NOT_IPV4;
         end else if (pos == OFF_IP_START) begin
            ihl = b[3:0];
            if (ihl < MIN_HDR_WORDS) st = ST_MALFORMED;
         end else begin
            ip_end = int'(OFF_IP_START) + int'(ihl) * 4;
            if (int'(pos) < ip_end) begin
               // inside the IPv4 header
               r = int'(pos) - int'(OFF_IP_START);
               if (r == 2 || r == 3) ip_len = {ip_len[7:0], b};
               else if (r == 9) proto = b;
               else if (r >= 12 && r <= 15) sip = {sip[23:0], b};
               else if (r >= 16 && r <= 19) dip = {dip[23:0], b};
               if (r == 19 && proto != PROTO_TCP) st = ST_NOT_TCP;
            end else begin
               // inside the TCP header
               r = int'(pos) - ip_end;
               if (r < 2) begin
                  sport = {sport[7:0], b};
               end else if (r < 4) begin
                  dport = {dport[7:0], b};
               end else if (r == int'(TCP_OFF_DOFF)) begin
                  doff = b[7:4];
                  if (doff < MIN_HDR_WORDS) st = ST_MALFORMED;
               end else if (r > int'(TCP_OFF_DOFF) && r == int'(doff) * 4 - 1) begin
                  st = ST_TCP_OK;
               end
            end
         end

         if (st < 0 && fin) st = ST_TRUNCATED;
         if (st >= 0) begin
            plen = 0;
            done = 1'b1;
            if (st == ST_TCP_OK) begin
               plen = int'(ip_len) - (int'(ihl) + int'(doff)) * 4;
               if (plen < 0) plen = 0;
               shown = (plen < int'(limit)) ? plen : int'(limit);
               if (shown != 0 && !fin) begin
                  done = 1'b0;
                  shown_left = 16'(shown);
               end
            end
            item.kind = KIND_SUMMARY;
            item.status = status_type'(st[2:0]);
            item.dst_mac = dmac;
            item.src_mac = smac;
            item.dst_ip = dip;
            item.src_ip = sip;
            item.src_port = sport;
            item.dst_port = dport;
            item.payload_len = 16'(plen);
            item.end_res = done;
            stage = done ? PH_DONE : PH_PAYLOAD;
            parsed_items.push_back(item);
         end
         if (pos != 16'hFFFF) pos = pos + 16'd1;
      end else if (stage == PH_PAYLOAD) begin
         // one payload item per byte until the shown count runs out
         shown_left = shown_left - 16'd1;
         item.kind = KIND_PAYLOAD;
         item.payload_byte = b;
         item.end_res = (shown_left == 16'd0) || fin;
         if (shown_left == 16'd0) stage = PH_DONE;
         parsed_items.push_back(item);
      end

      if (fin) clear_frame();
   endtask

   // Name every field that differs
   function automatic string field_diffs(input rsp_type want, input rsp_type got);
      string s;
      s = "";
      if (want.kind !== got.kind) s = {s, " kind"};
      if (want.status !== got.status) s = {s, " status"};
      if (want.dst_mac !== got.dst_mac) s = {s, " dst_mac"};
      if (want.src_mac !== got.src_mac) s = {s, " src_mac"};
      if (want.dst_ip !== got.dst_ip) s = {s, " dst_ip"};
      if (want.src_ip !== got.src_ip) s = {s, " src_ip"};
      if (want.src_port !== got.src_port) s = {s, " src_port"};
      if (want.dst_port !== got.dst_port) s = {s, " dst_port"};
      if (want.payload_len !== got.payload_len) s = {s, " payload_len"};
      if (want.payload_byte !== got.payload_byte) s = {s, " payload_byte"};
      if (want.end_res !== got.end_res) s = {s, " end_res"};
      return s;
   endfunction

   // Sample every channel at the rising edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         limit = SHOW_LIMIT_RESET;
         clear_frame();
         parsed_items.delete();
      end else begin
         if (csr_valid && csr_ready) limit = csr_data;

         // compare each result transfer with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (parsed_items.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result item %h at %0t", rsp_data, $time);
            end else begin
               want = parsed_items.pop_front();
               if (want !== rsp_data) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("result mismatch in%s at %0t: expected %h, got %h",
                              field_diffs(want, rsp_data), $time, want, rsp_data);
               end
            end
         end

         if (req_valid && !req_stall) parse_byte(req_data.data_byte, req_data.last);
      end
      mismatches <= error_count;
      outstanding <= parsed_items.size();
   end

endmodule

@@ test/tb_eth_ipv4_tcp_header_parser.sv @@
// Testbench top for the Ethernet/IPv4/TCP header parser: builds frames byte by byte,
// sets show_limit between frames and gives the verdict. Depends on eitp_pkg,
// eth_ipv4_tcp_header_parser and parser_result_checker.
module tb_eth_ipv4_tcp_header_parser;
   import eitp_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   int         mismatches;
   int         outstanding;
   bit         no_idle;
   int         bytes_sent;
   logic [7:0] frame[$];

   eth_ipv4_tcp_header_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   parser_result_checker u_result_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // 10-unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop for a hung run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Result side: stall for a random number of cycles before each transfer
   initial begin : rsp_side
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 14);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one byte after a random gap and hold it until the transfer
   task automatic send_byte(input logic [7:0] value, input logic fin);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {value, fin};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Send the built frame, cut short when cut is non-zero
   task automatic send_frame(input int cut);
      int len;
      len = frame.size();
      if (cut > 0 && cut < len) len = cut;
      for (int i = 0; i < len; i++) send_byte(frame[i], i == len - 1);
   endtask

   // Lay out Ethernet, IPv4 and TCP headers with random content, then payload and padding
   task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [3:0] doff,
                              input int n_payload, input bit fix_len, input int n_pad);
      logic [15:0] tlen;
      frame.delete();
      repeat (12) frame.push_back(8'($urandom));
      frame.push_back(etype[15:8]);
      frame.push_back(etype[7:0]);
      frame.push_back({4'($urandom), ihl});
      frame.push_back(8'($urandom));
      tlen = fix_len ? 16'(int'(ihl) * 4 + int'(doff) * 4 + n_payload) : 16'($urandom);
      frame.push_back(tlen[15:8]);
      frame.push_back(tlen[7:0]);
      repeat (5) frame.push_back(8'($urandom));
      frame.push_back(proto);
      repeat (10) frame.push_back(8'($urandom));
      for (int k = 5; k < int'(ihl); k++) repeat (4) frame.push_back(8'($urandom));
      repeat (12) frame.push_back(8'($urandom));
      frame.push_back({doff, 4'($urandom)});
      for (int k = 13; k < int'(doff) * 4; k++) frame.push_back(8'($urandom));
      repeat (n_payload) frame.push_back(8'($urandom));
      repeat (n_pad) frame.push_back(8'($urandom));
   endtask

   // Overwrite MAC, IP address and port bytes of a plain 20-byte IP header frame
   task automatic fill_addresses(input logic [7:0] value);
      for (int k = 0; k < 38; k++) if (k < 12 || k >= 26) frame[k] = value;
   endtask

   // Wait until every predicted item has arrived and the pipeline has emptied
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_show_limit(input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One frame from a weighted mix: mostly clean TCP, the rest broken or noise
   task automatic send_random_frame();
      int          sel;
      int          n;
      int          cut;
      logic [3:0]  ihl;
      logic [3:0]  doff;
      logic [15:0] etype;
      logic [7:0]  proto;
      sel = $urandom_range(0, 99);
      cut = 0;
      ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : MIN_HDR_WORDS;
      doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : MIN_HDR_WORDS;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
      no_idle = ($urandom_range(0, 3) == 0);
      if (sel < 60) begin
         build_frame(ETHERTYPE_IPV4, ihl, PROTO_TCP, doff, n, $urandom_range(0, 4) != 0,
                     $urandom_range(0, 6));
      end else if (sel < 68) begin
         etype = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                             : ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15));
         if (etype == ETHERTYPE_IPV4) etype = 16'h86DD;
         build_frame(etype, ihl, PROTO_TCP, doff, n, 1'b1, $urandom_range(0, 6));
      end else if (sel < 76) begin
         proto = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                             : PROTO_TCP ^ (8'd1 << $urandom_range(0, 7));
         if (proto == PROTO_TCP) proto = 8'd17;
         build_frame(ETHERTYPE_IPV4, ihl, proto, doff, n, 1'b1, $urandom_range(0, 6));
      end else if (sel < 80) begin
         build_frame(ETHERTYPE_IPV4, 4'($urandom_range(0, 4)), PROTO_TCP, doff, n, 1'b1, 0);
      end else if (sel < 84) begin
         build_frame(ETHERTYPE_IPV4, ihl, PROTO_TCP, 4'($urandom_range(0, 4)), n, 1'b1, 0);
      end else if (sel < 92) begin
         build_frame(ETHERTYPE_IPV4, ihl, PROTO_TCP, doff, n, 1'b1, 0);
         cut = $urandom_range(1, frame.size());
      end else begin
         frame.delete();
         repeat ($urandom_range(1, 80)) frame.push_back(8'($urandom));
      end
      send_frame(cut);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      bytes_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames at the reset show_limit
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 3, 1'b1, 0);
      fill_addresses(8'hFF);
      send_frame(0);
      frame = '{8'hFF};
      send_frame(0);
      // not IPv4, ending right on the ethertype
      build_frame(16'h86DD, 4'd5, PROTO_TCP, 4'd5, 0, 1'b1, 0);
      send_frame(14);
      // IP header length below five words, one byte after it
      build_frame(ETHERTYPE_IPV4, 4'd4, PROTO_TCP, 4'd5, 4, 1'b1, 0);
      send_frame(16);
      // IPv4 carrying UDP with options, cut after the options
      build_frame(ETHERTYPE_IPV4, 4'd6, 8'd17, 4'd5, 4, 1'b1, 2);
      send_frame(40);
      // TCP data offset below five words
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd4, 4, 1'b1, 0);
      send_frame(48);
      // header ends on the final byte
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 5, 1'b1, 0);
      send_frame(54);
      // truncated inside the source address
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 2, 1'b1, 0);
      send_frame(30);

      // Nothing shown; total length below the header lengths clamps to zero
      drain();
      write_show_limit(8'd0);
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 2, 1'b1, 0);
      frame[16] = 8'h00;
      frame[17] = 8'd20;
      send_frame(0);

      // Widest show limit, frame ends in the middle of the payload
      drain();
      write_show_limit(8'd255);
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 20, 1'b1, 0);
      send_frame(64);

      // Random frames, a fresh show limit before each
      while (bytes_sent < 450) begin
         drain();
         case ($urandom_range(0, 4))
            0: write_show_limit(8'd0);
            1: write_show_limit(8'd1);
            2: write_show_limit(8'd255);
            default: write_show_limit(8'($urandom_range(2, 30)));
         endcase
         send_random_frame();
      end

      no_idle = 1'b0;
      drain();
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
